>>> hdl/kwm_pkg.sv
package kwm_pkg;

  localparam int unsigned SRC_W = 2;
  localparam int unsigned TS_W  = 64;
  localparam int unsigned PL_W  = 32;

  // Request kinds.
  localparam logic REQ_EVENT = 1'b0;
  localparam logic REQ_END   = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [SRC_W-1:0] source_index;
    logic [TS_W-1:0]  event_timestamp;
    logic [PL_W-1:0]  event_payload;
  } req_t;

  typedef struct packed {
    logic [SRC_W-1:0] out_source;
    logic [TS_W-1:0]  out_timestamp;
    logic [PL_W-1:0]  out_payload;
    logic             status;
    logic             last_of_run;
    logic             all_done;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_PICK,
    ST_OUT
  } state_t;

endpackage

>>> hdl/k_way_timestamp_merge_top.sv
// Channel   Direction  Handshake             Payload
// request   in         req_valid / req_stall req  (kwm_pkg::req_t)
// response  out        rsp_valid / rsp_stall rsp  (kwm_pkg::rsp_t)
//
// One request is taken at a time. Each merged result comes from a walk of the slot
// memory (one entry read and compared per cycle, through a registered read port).
// Reset (rst, synchronous) clears the pending and finished marks; the slot memory
// holds no reset value. A stalled response simply holds the block in ST_OUT.
module k_way_timestamp_merge_top #(
  parameter int unsigned NUM_SOURCES = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  kwm_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output kwm_pkg::rsp_t rsp
);
  import kwm_pkg::*;

  // Index width for the slot memory, and a width wide enough to hold the
  // source field, any slot index and the source count itself.
  localparam int unsigned IW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int unsigned XW = ((IW + 1) > SRC_W) ? (IW + 1) : SRC_W;

  // Each slot holds the timestamp and payload of its pending event.
  typedef struct packed {
    logic [TS_W-1:0] ts;
    logic [PL_W-1:0] pl;
  } slot_t;

  state_t state;
  state_t state_next;

  logic [NUM_SOURCES-1:0] slot_valid;
  logic [NUM_SOURCES-1:0] source_finished;

  // Slot memory: one write port (request), one read port (scan).
  slot_t mem [NUM_SOURCES];
  slot_t rd_word;

  logic [IW-1:0] scan_cnt;
  logic          cmp_vld;
  logic [IW-1:0] cmp_idx;

  logic          best_found;
  logic [IW-1:0] best_idx;
  slot_t         best_word;

  rsp_t rsp_q;

  // Decode of the incoming request.
  logic [XW-1:0] src_ext;
  logic [IW-1:0] src_idx;
  logic          src_oob;
  logic          reject;
  logic          req_acc;

  assign src_ext = XW'(req.source_index);
  assign src_idx = src_ext[IW-1:0];
  assign src_oob = (src_ext >= XW'(NUM_SOURCES));
  assign reject  = src_oob || source_finished[src_idx] ||
                   ((req.req_type == REQ_EVENT) && slot_valid[src_idx]);
  assign req_acc = req_valid && !req_stall;

  // A merge step is possible when every unfinished source has an event
  // pending and at least one event is pending.
  logic can_emit;
  logic all_fin;
  assign can_emit = (&(source_finished | slot_valid)) && (|slot_valid);
  assign all_fin  = &source_finished;

  // The same test as it will look once the chosen slot is freed; it sets the
  // run flags of the result being formed.
  logic [NUM_SOURCES-1:0] valid_after;
  logic                   can_after;
  assign valid_after = slot_valid & ~(NUM_SOURCES'(1) << best_idx);
  assign can_after   = (&(source_finished | valid_after)) && (|valid_after);

  // The comparison stage sees one memory word per cycle; ties keep the
  // earlier, lower-indexed slot since the walk goes upward.
  logic take;
  assign take = cmp_vld && slot_valid[cmp_idx] &&
                (!best_found || (rd_word.ts < best_word.ts));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_acc) begin
          state_next = reject ? ST_OUT : ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = can_emit ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_cnt == IW'(NUM_SOURCES - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_PICK;
      ST_PICK:  state_next = ST_OUT;
      ST_OUT: begin
        if (!rsp_stall) begin
          state_next = ST_CHECK;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    req_stall = 1'b1;
    rsp_valid = 1'b0;
    case (state)
      ST_IDLE: req_stall = 1'b0;
      ST_OUT:  rsp_valid = 1'b1;
      default: begin
        req_stall = 1'b1;
        rsp_valid = 1'b0;
      end
    endcase
  end

  assign rsp = rsp_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Slot memory. Requests write only in ST_IDLE and the walk uses reads only from ST_SCAN (the read
  // port itself reads every cycle), so accesses to one entry never overlap.
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && req_acc && !reject && (req.req_type == REQ_EVENT)) begin
      mem[src_idx] <= '{ts: req.event_timestamp, pl: req.event_payload};
    end
    rd_word <= mem[scan_cnt];
  end

  // Pending and finished marks, scan control.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid      <= '0;
      source_finished <= '0;
      scan_cnt        <= '0;
      cmp_vld         <= 1'b0;
      cmp_idx         <= '0;
      best_found      <= 1'b0;
    end else begin
      cmp_vld <= (state == ST_SCAN);
      cmp_idx <= scan_cnt;
      case (state)
        ST_IDLE: begin
          if (req_acc && !reject) begin
            if (req.req_type == REQ_EVENT) begin
              slot_valid[src_idx] <= 1'b1;
            end else begin
              source_finished[src_idx] <= 1'b1;
            end
          end
        end
        ST_CHECK: begin
          scan_cnt   <= '0;
          best_found <= 1'b0;
          // The last source has finished and nothing is left to merge.
          if (!can_emit && all_fin) begin
            slot_valid      <= '0;
            source_finished <= '0;
          end
        end
        ST_SCAN: begin
          scan_cnt <= scan_cnt + IW'(1);
          if (take) begin
            best_found <= 1'b1;
          end
        end
        ST_DRAIN: begin
          if (take) begin
            best_found <= 1'b1;
          end
        end
        ST_PICK: begin
          slot_valid <= valid_after;
        end
        default: begin
        end
      endcase
    end
  end

  // Best candidate and response register.
  always_ff @(posedge clk) begin
    if (take) begin
      best_idx  <= cmp_idx;
      best_word <= rd_word;
    end
    if ((state == ST_IDLE) && req_acc && reject) begin
      rsp_q.out_source    <= req.source_index;
      rsp_q.out_timestamp <= '0;
      rsp_q.out_payload   <= '0;
      rsp_q.status        <= STATUS_REJECT;
      rsp_q.last_of_run   <= 1'b1;
      rsp_q.all_done      <= 1'b0;
    end else if (state == ST_PICK) begin
      rsp_q.out_source    <= SRC_W'(best_idx);
      rsp_q.out_timestamp <= best_word.ts;
      rsp_q.out_payload   <= best_word.pl;
      rsp_q.status        <= STATUS_OK;
      rsp_q.last_of_run   <= !can_after;
      rsp_q.all_done      <= !can_after && all_fin;
    end
  end

endmodule

>>> hdl/kwm_checker.sv
module kwm_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input kwm_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input kwm_pkg::rsp_t rsp
);
  import kwm_pkg::*;

  // A held response keeps its value.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // No new request is taken while a response waits.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> req_stall)
    else $error("request port open while a response is pending");

  // A rejection is always a run of one and never ends the stream.
  a_reject: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == STATUS_REJECT) |->
      rsp.last_of_run && !rsp.all_done && (rsp.out_timestamp == '0))
    else $error("malformed rejection");

  // The end of the stream closes the run.
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.all_done |-> rsp.last_of_run)
    else $error("stream end without run end");

endmodule

bind k_way_timestamp_merge_top kwm_checker u_kwm_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
